@@ hw/rtl/chs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package chs_pkg;
   localparam int BUCKETS_DEF    = 13;
   localparam int POOL_NODES_DEF = 256;
   localparam int NAME_BYTES_DEF = 8;
   localparam int KEY_W          = 31;
   localparam int PAY_W          = 64;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_DELETE = 2'd1;
   localparam logic [1:0] MODE_SEARCH = 2'd2;

   localparam logic [1:0] ST_DONE      = 2'd0;
   localparam logic [1:0] ST_DUPLICATE = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

   typedef struct packed {
      logic [1:0]       mode;
      logic [KEY_W-1:0] key;
      logic [PAY_W-1:0] payload;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [PAY_W-1:0] found_payload;
   } rsp_type;
endpackage
`default_nettype wire

@@ hw/rtl/chs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Takes a transaction, works out its bucket, and pushes a decoded command
// into a two-entry queue toward the chain engine.
module chs_front #(
   parameter int BUCKETS    = chs_pkg::BUCKETS_DEF,
   parameter int NAME_BYTES = chs_pkg::NAME_BYTES_DEF,
   parameter int BKT_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  chs_pkg::req_type      req_data,
   output logic                  busy,
   output logic                  cmd_valid,
   output chs_pkg::req_type      cmd_data,
   output logic [BKT_W-1:0]      cmd_bucket,
   input  wire logic             cmd_pop
);
   import chs_pkg::*;

   localparam int NB_BITS = 8 * NAME_BYTES;
   // floor(2^KEY_W / BUCKETS): the quotient estimate is low by at most one
   localparam longint unsigned RECIP_L = (64'd1 << KEY_W) / 64'(BUCKETS);
   localparam logic [KEY_W-1:0] RECIP  = KEY_W'(RECIP_L);
   localparam logic [KEY_W:0]   BKT_K  = (KEY_W+1)'(BUCKETS);

   // step 0: multiply by the reciprocal; step 1: remainder; step 2: correct and queue
   logic               s0_valid_ff, s0_valid_in;
   req_type            s0_data_ff, s0_data_in;
   logic [2*KEY_W-1:0] prod_ff;
   logic [KEY_W-1:0]   quot;
   logic [KEY_W:0]     rem_ff, rem_in;
   logic [KEY_W:0]     rem_fix;
   logic [1:0]         step_ff, step_in;
   logic               q_valid_ff [2];
   req_type            q_data_ff  [2];
   logic [BKT_W-1:0]   q_bkt_ff   [2];
   logic               wr_ptr_ff, rd_ptr_ff;

   logic               accept;
   logic               done_red;

   assign accept   = start && !busy;
   assign done_red = s0_valid_ff && (step_ff == 2'd2);
   assign busy     = s0_valid_ff || q_valid_ff[wr_ptr_ff];
   assign quot     = prod_ff[2*KEY_W-1:KEY_W];
   assign rem_in   = {1'b0, s0_data_ff.key} - {1'b0, quot} * BKT_K;
   assign rem_fix  = (rem_ff >= BKT_K) ? (rem_ff - BKT_K) : rem_ff;

   always_comb begin
      s0_data_in  = req_data;
      if (NB_BITS < PAY_W)
         s0_data_in.payload = req_data.payload & ~({PAY_W{1'b1}} << NB_BITS);
      step_in     = step_ff;
      s0_valid_in = s0_valid_ff;
      if (accept) begin
         s0_valid_in = 1'b1;
         step_in     = 2'd0;
      end else if (done_red) begin
         s0_valid_in = 1'b0;
      end else if (s0_valid_ff) begin
         step_in = step_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         step_ff     <= '0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         step_ff     <= step_in;
      end
      if (s0_valid_ff && step_ff == 2'd0)
         prod_ff <= (2*KEY_W)'(s0_data_ff.key) * (2*KEY_W)'(RECIP);
      if (s0_valid_ff && step_ff == 2'd1)
         rem_ff <= rem_in;
      if (accept)
         s0_data_ff <= s0_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff[0] <= 1'b0;
         q_valid_ff[1] <= 1'b0;
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
      end else begin
         if (done_red) begin
            q_valid_ff[wr_ptr_ff] <= 1'b1;
            wr_ptr_ff             <= ~wr_ptr_ff;
         end
         if (cmd_pop) begin
            q_valid_ff[rd_ptr_ff] <= 1'b0;
            rd_ptr_ff             <= ~rd_ptr_ff;
         end
      end
      if (done_red) begin
         q_data_ff[wr_ptr_ff] <= s0_data_ff;
         q_bkt_ff[wr_ptr_ff]  <= BKT_W'(rem_fix);
      end
   end

   assign cmd_valid  = q_valid_ff[rd_ptr_ff];
   assign cmd_data   = q_data_ff[rd_ptr_ff];
   assign cmd_bucket = q_bkt_ff[rd_ptr_ff];
endmodule
`default_nettype wire

@@ hw/rtl/chs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Chain engine: walks a bucket chain through the node memories and
// applies insert, delete or search.
module chs_back #(
   parameter int BUCKETS    = chs_pkg::BUCKETS_DEF,
   parameter int POOL_NODES = chs_pkg::POOL_NODES_DEF,
   parameter int BKT_W      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          cmd_valid,
   input  chs_pkg::req_type   cmd_data,
   input  wire logic [BKT_W-1:0] cmd_bucket,
   output logic               cmd_pop,
   output logic               rsp_strobe,
   output chs_pkg::rsp_type   rsp_data,
   output logic               init_busy
);
   import chs_pkg::*;

   localparam int IDX_W = $clog2(POOL_NODES);
   localparam int LNK_W = IDX_W + 1;
   localparam logic [LNK_W-1:0] NIL = LNK_W'(POOL_NODES);

   localparam logic [2:0] S_INIT  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_READ  = 3'd2;
   localparam logic [2:0] S_CMP   = 3'd3;
   localparam logic [2:0] S_INS   = 3'd4;
   localparam logic [2:0] S_DEL   = 3'd5;
   localparam logic [2:0] S_REPLY = 3'd6;

   logic [KEY_W-1:0] key_mem  [POOL_NODES];
   logic [PAY_W-1:0] pay_mem  [POOL_NODES];
   logic [LNK_W-1:0] link_mem [POOL_NODES];
   logic [IDX_W-1:0] free_mem [POOL_NODES];
   logic [LNK_W-1:0] head_ff  [BUCKETS];

   logic [2:0]       state_ff;
   logic [LNK_W-1:0] free_count_ff;
   logic [IDX_W-1:0] init_ff;
   req_type          cmd_ff;
   logic [BKT_W-1:0] bkt_ff;
   logic [LNK_W-1:0] cur_ff, prev_ff;
   logic [LNK_W:0]   steps_ff;
   logic [KEY_W-1:0] rd_key_ff;
   logic [PAY_W-1:0] rd_pay_ff;
   logic [LNK_W-1:0] rd_link_ff;
   logic [IDX_W-1:0] rd_free_ff;
   logic [1:0]       status_ff;
   logic [PAY_W-1:0] found_ff;
   logic             strobe_ff;

   logic [IDX_W-1:0] cur_idx;
   logic [IDX_W-1:0] free_top;
   assign cur_idx  = cur_ff[IDX_W-1:0];
   assign free_top = IDX_W'(free_count_ff - LNK_W'(1));

   assign cmd_pop    = (state_ff == S_IDLE) && cmd_valid;
   assign init_busy  = (state_ff == S_INIT);
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = '{status: status_ff, found_payload: found_ff};

   // memory reads, registered
   always_ff @(posedge clock) begin
      rd_key_ff  <= key_mem[cur_idx];
      rd_pay_ff  <= pay_mem[cur_idx];
      rd_link_ff <= link_mem[cur_idx];
      rd_free_ff <= free_mem[free_top];
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_INIT)
         free_mem[init_ff] <= IDX_W'(POOL_NODES - 1) - init_ff;
      else if (state_ff == S_DEL && free_count_ff < NIL)
         free_mem[free_count_ff[IDX_W-1:0]] <= cur_idx;
      if (state_ff == S_INS && free_count_ff != '0) begin
         key_mem[rd_free_ff]  <= cmd_ff.key;
         pay_mem[rd_free_ff]  <= cmd_ff.payload;
         link_mem[rd_free_ff] <= head_ff[bkt_ff];
      end
      if (state_ff == S_DEL && prev_ff != NIL)
         link_mem[prev_ff[IDX_W-1:0]] <= rd_link_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff     <= 1'b0;
         state_ff      <= S_INIT;
         init_ff       <= '0;
         free_count_ff <= NIL;
         for (int i = 0; i < BUCKETS; i++) head_ff[i] <= NIL;
      end else begin
         strobe_ff <= (state_ff == S_REPLY);
         case (state_ff)
            S_INIT: begin
               init_ff <= init_ff + IDX_W'(1);
               if (init_ff == IDX_W'(POOL_NODES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff    <= cmd_data;
                  bkt_ff    <= cmd_bucket;
                  cur_ff    <= head_ff[cmd_bucket];
                  prev_ff   <= NIL;
                  steps_ff  <= '0;
                  status_ff <= ST_DONE;
                  found_ff  <= '0;
                  if (cmd_data.mode == MODE_INSERT || cmd_data.mode == MODE_DELETE
                      || cmd_data.mode == MODE_SEARCH)
                     state_ff <= S_READ;
                  else
                     state_ff <= S_REPLY;
               end
            end
            S_READ: begin
               // off the chain, or the step bound reached: end of walk
               if (cur_ff >= NIL || steps_ff >= (LNK_W+1)'(POOL_NODES)) begin
                  case (cmd_ff.mode)
                     MODE_INSERT: begin
                        if (free_count_ff == '0) begin
                           status_ff <= ST_FULL;
                           state_ff  <= S_REPLY;
                        end else begin
                           state_ff  <= S_INS;
                        end
                     end
                     default: begin
                        status_ff <= ST_NOT_FOUND;
                        state_ff  <= S_REPLY;
                     end
                  endcase
               end else begin
                  state_ff <= S_CMP;
               end
            end
            S_CMP: begin
               if (rd_key_ff == cmd_ff.key) begin
                  case (cmd_ff.mode)
                     MODE_INSERT: begin
                        status_ff <= ST_DUPLICATE;
                        state_ff  <= S_REPLY;
                     end
                     MODE_DELETE: state_ff <= S_DEL;
                     default: begin
                        found_ff <= rd_pay_ff;
                        state_ff <= S_REPLY;
                     end
                  endcase
               end else begin
                  prev_ff  <= cur_ff;
                  cur_ff   <= rd_link_ff;
                  steps_ff <= steps_ff + (LNK_W+1)'(1);
                  state_ff <= S_READ;
               end
            end
            S_INS: begin
               head_ff[bkt_ff] <= {1'b0, rd_free_ff};
               free_count_ff   <= free_count_ff - LNK_W'(1);
               state_ff        <= S_REPLY;
            end
            S_DEL: begin
               if (prev_ff == NIL) head_ff[bkt_ff] <= rd_link_ff;
               if (free_count_ff < NIL) free_count_ff <= free_count_ff + LNK_W'(1);
               state_ff <= S_REPLY;
            end
            S_REPLY: begin
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/chained_hash_set.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                      Handshake
// request   start, busy, req_data      taken when start && !busy
// response  rsp_strobe, rsp_data       one cycle, no back-pressure
//
// The front finds the bucket by reciprocal multiply, remainder and fix-up,
// then queues the command. The chain engine reads and compares each node
// it visits; an insert that links a node, or a delete, has its own state,
// and mode 3 goes straight to the reply. Busy stays high after reset while
// all POOL_NODES free stack entries are filled. Results cannot be stalled.
module chained_hash_set #(
   parameter int BUCKETS    = chs_pkg::BUCKETS_DEF,
   parameter int POOL_NODES = chs_pkg::POOL_NODES_DEF,
   parameter int NAME_BYTES = chs_pkg::NAME_BYTES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  chs_pkg::req_type req_data,
   output logic             busy,
   output logic             rsp_strobe,
   output chs_pkg::rsp_type rsp_data
);
   import chs_pkg::*;

   localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

   logic             cmd_valid, cmd_pop, front_busy, init_busy;
   req_type          cmd_data;
   logic [BKT_W-1:0] cmd_bucket;

   assign busy = front_busy || init_busy;

   chs_front #(.BUCKETS(BUCKETS), .NAME_BYTES(NAME_BYTES), .BKT_W(BKT_W)) u_front (
      .clock(clock), .reset(reset), .start(start && !init_busy), .req_data(req_data),
      .busy(front_busy), .cmd_valid(cmd_valid), .cmd_data(cmd_data),
      .cmd_bucket(cmd_bucket), .cmd_pop(cmd_pop)
   );

   chs_back #(.BUCKETS(BUCKETS), .POOL_NODES(POOL_NODES), .BKT_W(BKT_W)) u_back (
      .clock(clock), .reset(reset), .cmd_valid(cmd_valid), .cmd_data(cmd_data),
      .cmd_bucket(cmd_bucket), .cmd_pop(cmd_pop), .rsp_strobe(rsp_strobe),
      .rsp_data(rsp_data), .init_busy(init_busy)
   );

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid) else $error("pop of empty queue");
   a_bucket_range: assert property (@(posedge clock) disable iff (reset)
      cmd_valid |-> (int'(cmd_bucket) < BUCKETS)) else $error("bucket out of range");
   a_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != ST_DONE |-> rsp_data.found_payload == '0)
      else $error("payload on failed lookup");
endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import chs_pkg::*;

   localparam int NBUCK = 13;
   localparam int NPOOL = 256;
   localparam logic [8:0] EMPTY = 9'd256;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   chained_hash_set DUT (
      .clock(clock), .reset(reset), .start(start), .req_data(req_data),
      .busy(busy), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   // shadow of the hash table
   logic [8:0]       head_q [NBUCK];
   logic [KEY_W-1:0] node_key_q [NPOOL];
   logic [PAY_W-1:0] node_pay_q [NPOOL];
   logic [8:0]       node_link_q [NPOOL];
   logic [7:0]       free_q [NPOOL];
   int               free_cnt;

   rsp_type          pending_rsp [$];
   logic [KEY_W-1:0] live_keys [$];
   int               mismatches;
   logic             timed_out;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #100ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic void table_reset();
      for (int i = 0; i < NBUCK; i++) head_q[i] = EMPTY;
      for (int i = 0; i < NPOOL; i++) free_q[i] = 8'(NPOOL - 1 - i);
      free_cnt = NPOOL;
   endfunction

   // walk one chain; returns node or EMPTY and its predecessor
   function automatic logic [8:0] walk_chain(input int b, input logic [KEY_W-1:0] k,
                                             output logic [8:0] prev);
      logic [8:0] cur;
      prev = EMPTY;
      cur = head_q[b];
      for (int s = 0; s < NPOOL && cur < EMPTY; s++) begin
         if (node_key_q[cur[7:0]] == k) return cur;
         prev = cur;
         cur = node_link_q[cur[7:0]];
      end
      prev = EMPTY;
      return EMPTY;
   endfunction

   function automatic rsp_type apply_op(input req_type r);
      rsp_type    o;
      logic [8:0] node, prev;
      int         b;
      o = '0;
      b = int'(r.key % NBUCK);
      node = walk_chain(b, r.key, prev);
      case (r.mode)
         MODE_INSERT: begin
            if (node != EMPTY) o.status = ST_DUPLICATE;
            else if (free_cnt == 0) o.status = ST_FULL;
            else begin
               free_cnt--;
               node = {1'b0, free_q[free_cnt]};
               node_key_q[node[7:0]] = r.key;
               node_pay_q[node[7:0]] = r.payload;
               node_link_q[node[7:0]] = head_q[b];
               head_q[b] = node;
               live_keys.push_back(r.key);
            end
         end
         MODE_DELETE: begin
            if (node == EMPTY) o.status = ST_NOT_FOUND;
            else begin
               if (prev == EMPTY) head_q[b] = node_link_q[node[7:0]];
               else node_link_q[prev[7:0]] = node_link_q[node[7:0]];
               free_q[free_cnt] = node[7:0];
               free_cnt++;
               foreach (live_keys[i])
                  if (live_keys[i] == r.key) begin
                     live_keys.delete(i);
                     break;
                  end
            end
         end
         MODE_SEARCH: begin
            if (node == EMPTY) o.status = ST_NOT_FOUND;
            else o.found_payload = node_pay_q[node[7:0]];
         end
         default: ;
      endcase
      return o;
   endfunction

   task automatic send_op(input logic [1:0] m, input logic [KEY_W-1:0] k,
                          input logic [PAY_W-1:0] p, input bit gaps = 1);
      req_type r;
      int      gap;
      r.mode = m;
      r.key = k;
      r.payload = p;
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(apply_op(r));
      @(negedge clock);
      gap = 0;
      if (gaps) gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
                      $urandom_range(0, 2);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic logic [KEY_W-1:0] any_live_key();
      if (live_keys.size() == 0) return KEY_W'($urandom);
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
   endfunction

   function automatic logic [PAY_W-1:0] rand_payload();
      return {$urandom, $urandom};
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: status %0d payload %h",
                        rsp_data.status, rsp_data.found_payload);
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.status !== exp_rsp.status ||
                rsp_data.found_payload !== exp_rsp.found_payload) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp status %0d payload %h, got %0d %h",
                           exp_rsp.status, exp_rsp.found_payload,
                           rsp_data.status, rsp_data.found_payload);
            end
         end
      end
   end

   task automatic test_directed();
      send_op(MODE_SEARCH, 31'd0, '0);
      send_op(MODE_DELETE, 31'h7FFF_FFFF, '0);
      send_op(MODE_INSERT, 31'd0, '0);
      send_op(MODE_INSERT, 31'h7FFF_FFFF, '1);
      send_op(MODE_INSERT, 31'd13, 64'h0123_4567_89AB_CDEF);
      send_op(MODE_INSERT, 31'd26, 64'hFEDC_BA98_7654_3210);
      send_op(MODE_INSERT, 31'd13, 64'h5555);
      send_op(MODE_SEARCH, 31'd0, '1);
      send_op(MODE_SEARCH, 31'd13, '0);
      send_op(MODE_SEARCH, 31'h7FFF_FFFF, '0);
      send_op(MODE_SEARCH, 31'd39, '0);
      // unlink from the middle, then head, then tail of one chain
      send_op(MODE_DELETE, 31'd13, '0);
      send_op(MODE_DELETE, 31'd26, '0);
      send_op(MODE_DELETE, 31'd0, '0);
      send_op(MODE_DELETE, 31'd0, '0);
      send_op(2'd3, 31'h5555_5555, '1);
      send_op(MODE_SEARCH, 31'h2AAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);
   endtask

   // fill the pool completely and overflow it
   task automatic test_pool_full();
      while (free_cnt > 0)
         send_op(MODE_INSERT, KEY_W'($urandom), rand_payload(), 0);
      send_op(MODE_INSERT, 31'd12345, rand_payload());
      send_op(MODE_INSERT, any_live_key(), rand_payload());
      repeat (20) send_op(MODE_SEARCH, any_live_key(), '0);
      while (live_keys.size() > 200)
         send_op(MODE_DELETE, any_live_key(), '0, 0);
   endtask

   task automatic test_random();
      int sel;
      logic [KEY_W-1:0] k;
      for (int n = 0; n < 200; n++) begin
         sel = $urandom_range(0, 99);
         // keep keys mostly in a small range so chains collide
         k = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom) : KEY_W'($urandom_range(0, 120));
         if (sel < 35) send_op(MODE_INSERT, k, rand_payload());
         else if (sel < 50) send_op(MODE_DELETE, any_live_key(), rand_payload());
         else if (sel < 60) send_op(MODE_DELETE, k, rand_payload());
         else if (sel < 80) send_op(MODE_SEARCH, any_live_key(), rand_payload());
         else if (sel < 95) send_op(MODE_SEARCH, k, rand_payload());
         else send_op(2'd3, k, rand_payload());
      end
   endtask

   initial begin
      mismatches = 0;
      timed_out = 0;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      table_reset();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_pool_full();
      test_random();
      start <= 1'b0;
      fork
         wait (pending_rsp.size() == 0);
         begin
            repeat (20000) @(posedge clock);
            timed_out = 1;
         end
      join_any
      disable fork;
      repeat (50) @(posedge clock);
      if (timed_out || mismatches != 0 || pending_rsp.size() != 0)
         $display("Testbench completed WITH ERRORS");
      else
         $display("Testbench completed without errors");
      $finish;
   end
endmodule
